FILE: rtl/bsds_pkg.sv
// Package: shared constants, types and control structs of the dipole grid spreader.
package bsds_pkg;

  localparam int GRID_A_MAX = 32;
  localparam int GRID_B_MAX = 32;
  localparam int GRID_C_MAX = 32;
  localparam int MAX_ORDER  = 6;

  localparam int CELLS   = GRID_A_MAX * GRID_B_MAX * GRID_C_MAX;
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int IA_W    = $clog2(GRID_A_MAX);
  localparam int IB_W    = $clog2(GRID_B_MAX);
  localparam int IC_W    = $clog2(GRID_C_MAX);
  localparam int K_W     = $clog2(MAX_ORDER);
  localparam int GSZ_W   = 6;
  localparam int ORD_W   = 3;
  localparam int POS_W   = 21;
  localparam int FRAC_W  = 16;
  localparam int INT_W   = POS_W - FRAC_W;
  localparam int MU_W    = 24;
  localparam int SUM_W   = 48;
  localparam int FRAME_W = 32;
  localparam int RIDX_W  = 15;
  localparam int W_W     = 31;
  localparam int CFG_IW  = 3;
  localparam int CFG_DW  = 6;
  localparam int PH_W    = 3;
  localparam logic [PH_W-1:0] PH_LAST = PH_W'(6);

  localparam logic [1:0] FUNC_SPREAD = 2'd0;
  localparam logic [1:0] FUNC_FRAME  = 2'd1;
  localparam logic [1:0] FUNC_READ   = 2'd2;

  localparam logic [CFG_IW-1:0] REG_NA    = CFG_IW'(0);
  localparam logic [CFG_IW-1:0] REG_NB    = CFG_IW'(1);
  localparam logic [CFG_IW-1:0] REG_NC    = CFG_IW'(2);
  localparam logic [CFG_IW-1:0] REG_ORDER = CFG_IW'(3);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_WGT, ST_CELL, ST_DRAIN, ST_RD_SIZE, ST_RD_DATA
  } bsds_state_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] x;
    logic signed [SUM_W-1:0] y;
    logic signed [SUM_W-1:0] z;
  } cell_t;

  typedef struct packed {
    logic             capture;
    logic             frame_bump;
    logic [ORD_W-1:0] q;
    logic [ORD_W-1:0] j;
    logic             w_mul;
    logic             w_sum;
    logic             w_div;
    logic             w_write;
    logic             cell_step;
    logic             clear;
    logic             rd_size;
    logic             out_load;
  } bsds_cmd_t;

  typedef struct packed {
    logic [ORD_W-1:0] order;
    logic             cell_last;
    logic             pipe_busy;
    logic             clear_last;
    logic             out_free;
  } bsds_stat_t;

endpackage

FILE: rtl/bspline_dipole_grid_spreader_core.sv
// Top level: B-spline dipole spreader onto a periodic grid of saturating sums.
// Spread word: the shared weight recurrence for order p (skipped at order 1), then one
//   store update a cycle over the p^3 cells of the sweep, then a drain of the cell pipeline.
// End-of-frame word: bumps the frame count. Read word: loads the result register.
// Reset: config to 32/32/32/order 4, frame count to zero, then a clearing pass
//   over every cell of the sum store, during which no word is taken.
module bspline_dipole_grid_spreader_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [bsds_pkg::CFG_IW-1:0]        cfg_index,
  input  logic [bsds_pkg::CFG_DW-1:0]        cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         func,
  input  logic signed [bsds_pkg::MU_W-1:0]   mu_x,
  input  logic signed [bsds_pkg::MU_W-1:0]   mu_y,
  input  logic signed [bsds_pkg::MU_W-1:0]   mu_z,
  input  logic [bsds_pkg::POS_W-1:0]         pos_a,
  input  logic [bsds_pkg::POS_W-1:0]         pos_b,
  input  logic [bsds_pkg::POS_W-1:0]         pos_c,
  input  logic [bsds_pkg::RIDX_W-1:0]        read_index,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [bsds_pkg::SUM_W-1:0]  sum_x,
  output logic signed [bsds_pkg::SUM_W-1:0]  sum_y,
  output logic signed [bsds_pkg::SUM_W-1:0]  sum_z,
  output logic [bsds_pkg::FRAME_W-1:0]       frames
);
  import bsds_pkg::*;

  bsds_cmd_t  cmd;
  bsds_stat_t status;

  // controller: words are taken only in idle, one at a time
  bsds_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .func     (func),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: weights, cell pipeline, store and result register
  bsds_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mu_x       (mu_x),
    .mu_y       (mu_y),
    .mu_z       (mu_z),
    .pos_a      (pos_a),
    .pos_b      (pos_b),
    .pos_c      (pos_c),
    .read_index (read_index),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .sum_x      (sum_x),
    .sum_y      (sum_y),
    .sum_z      (sum_z),
    .frames     (frames)
  );

  // the store has one write port: clearing and cell updates never overlap
  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |-> !cmd.cell_step && !status.pipe_busy)
    else $error("clear overlaps cell updates");

  // a new word only once every update has landed
  a_drained: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !status.pipe_busy)
    else $error("word taken with updates in flight");

  // result register is loaded only when free
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> status.out_free)
    else $error("result register overwritten");

  // a result appears only after a load
  a_rise_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.out_load))
    else $error("result without load");

endmodule

FILE: rtl/bsds_ctrl.sv
// Controller: sequences clearing, weight recurrence, cell sweep and reads.
module bsds_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [1:0]           func,
  output logic                 in_stall,
  input  bsds_pkg::bsds_stat_t status,
  output bsds_pkg::bsds_cmd_t  cmd
);
  import bsds_pkg::*;

  bsds_state_t      state, state_next;
  logic [ORD_W-1:0] q, j;
  logic [PH_W-1:0]  ph;
  logic             accept;

  assign accept   = in_valid && (state == ST_IDLE);
  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (status.clear_last) state_next = ST_IDLE;
      ST_IDLE: begin
        if (in_valid) begin
          if (func == FUNC_SPREAD) begin
            state_next = (status.order == ORD_W'(1)) ? ST_CELL : ST_WGT;
          end else if (func == FUNC_READ) begin
            state_next = ST_RD_SIZE;
          end
        end
      end
      ST_WGT: begin
        if (ph == PH_LAST && j == '0 && q == status.order) state_next = ST_CELL;
      end
      ST_CELL:    if (status.cell_last) state_next = ST_DRAIN;
      ST_DRAIN:   if (!status.pipe_busy) state_next = ST_IDLE;
      ST_RD_SIZE: state_next = ST_RD_DATA;
      ST_RD_DATA: if (status.out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.q          = q;
    cmd.j          = j;
    cmd.capture    = accept;
    cmd.frame_bump = accept && (func == FUNC_FRAME);
    cmd.w_mul      = (state == ST_WGT) && (ph == '0);
    cmd.w_sum      = (state == ST_WGT) && (ph == PH_W'(1));
    cmd.w_div      = (state == ST_WGT) && (ph >= PH_W'(2));
    cmd.w_write    = (state == ST_WGT) && (ph == PH_LAST);
    cmd.cell_step  = (state == ST_CELL);
    cmd.clear      = (state == ST_CLEAR);
    cmd.rd_size    = (state == ST_RD_SIZE);
    cmd.out_load   = (state == ST_RD_DATA) && status.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      q     <= ORD_W'(2);
      j     <= ORD_W'(1);
      ph    <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        q  <= ORD_W'(2);
        j  <= ORD_W'(1);
        ph <= '0;
      end else if (state == ST_WGT) begin
        if (ph == PH_LAST) begin
          ph <= '0;
          if (j == '0) begin
            j <= q;
            q <= q + ORD_W'(1);
          end else begin
            j <= j - ORD_W'(1);
          end
        end else begin
          ph <= ph + PH_W'(1);
        end
      end
    end
  end

endmodule

FILE: rtl/bsds_dp.sv
// Datapath: config, spline weights, cell pipeline, sum store and result register.
module bsds_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  bsds_pkg::bsds_cmd_t                cmd,
  output bsds_pkg::bsds_stat_t               status,
  input  logic                               cfg_we,
  input  logic [bsds_pkg::CFG_IW-1:0]        cfg_index,
  input  logic [bsds_pkg::CFG_DW-1:0]        cfg_data,
  input  logic signed [bsds_pkg::MU_W-1:0]   mu_x,
  input  logic signed [bsds_pkg::MU_W-1:0]   mu_y,
  input  logic signed [bsds_pkg::MU_W-1:0]   mu_z,
  input  logic [bsds_pkg::POS_W-1:0]         pos_a,
  input  logic [bsds_pkg::POS_W-1:0]         pos_b,
  input  logic [bsds_pkg::POS_W-1:0]         pos_c,
  input  logic [bsds_pkg::RIDX_W-1:0]        read_index,
  input  logic                               out_stall,
  output logic                               out_valid,
  output logic signed [bsds_pkg::SUM_W-1:0]  sum_x,
  output logic signed [bsds_pkg::SUM_W-1:0]  sum_y,
  output logic signed [bsds_pkg::SUM_W-1:0]  sum_z,
  output logic [bsds_pkg::FRAME_W-1:0]       frames
);
  import bsds_pkg::*;

  localparam int XW = FRAC_W + 3;
  localparam int PW = XW + W_W;
  localparam int DVW = 40;
  localparam int CW = MU_W + 2;
  localparam logic [W_W-1:0] ONE30 = W_W'(1) << 30;

  function automatic logic [GSZ_W-1:0] clamp_sz(input logic [GSZ_W-1:0] v,
                                                input logic [GSZ_W-1:0] hi);
    if (v == '0) return GSZ_W'(1);
    if (v > hi)  return hi;
    return v;
  endfunction

  // remainder of a small integer part by the grid size, bit at a time
  function automatic logic [GSZ_W-1:0] mod_int(input logic [INT_W-1:0] v,
                                               input logic [GSZ_W-1:0] n);
    logic [GSZ_W-1:0] r;
    r = '0;
    for (int i = INT_W - 1; i >= 0; i--) begin
      r = {r[GSZ_W-2:0], v[i]};
      if (r >= n) r = r - n;
    end
    return r;
  endfunction

  // eight bits of quotient by a divisor of one to five
  function automatic logic [ORD_W+7:0] div8(input logic [ORD_W-1:0] rem,
                                            input logic [7:0] byt,
                                            input logic [ORD_W-1:0] d);
    logic [ORD_W:0] r;
    logic [7:0]     qb;
    r  = {1'b0, rem};
    qb = '0;
    for (int i = 7; i >= 0; i--) begin
      r = {r[ORD_W-1:0], byt[i]};
      if (r >= {1'b0, d}) begin
        r     = r - {1'b0, d};
        qb[i] = 1'b1;
      end
    end
    return {r[ORD_W-1:0], qb};
  endfunction

  function automatic cell_t sat_add(input cell_t b, input logic signed [CW-1:0] cx,
                                    input logic signed [CW-1:0] cy,
                                    input logic signed [CW-1:0] cz);
    logic signed [SUM_W:0] s [3];
    logic signed [SUM_W:0] smax, smin;
    cell_t r;
    smax = signed'({2'b00, {(SUM_W-1){1'b1}}});
    smin = signed'({2'b11, {(SUM_W-1){1'b0}}});
    s[0] = (SUM_W+1)'(b.x) + (SUM_W+1)'(cx);
    s[1] = (SUM_W+1)'(b.y) + (SUM_W+1)'(cy);
    s[2] = (SUM_W+1)'(b.z) + (SUM_W+1)'(cz);
    for (int i = 0; i < 3; i++) begin
      if (s[i] > smax) s[i] = smax;
      if (s[i] < smin) s[i] = smin;
    end
    r.x = s[0][SUM_W-1:0];
    r.y = s[1][SUM_W-1:0];
    r.z = s[2][SUM_W-1:0];
    return r;
  endfunction

  // config, kept clamped
  logic [GSZ_W-1:0] na, nb, nc;
  logic [ORD_W-1:0] order;

  always_ff @(posedge clk) begin
    if (rst) begin
      na    <= GSZ_W'(32);
      nb    <= GSZ_W'(32);
      nc    <= GSZ_W'(32);
      order <= ORD_W'(4);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NA: na <= clamp_sz(cfg_data, GSZ_W'(GRID_A_MAX));
        REG_NB: nb <= clamp_sz(cfg_data, GSZ_W'(GRID_B_MAX));
        REG_NC: nc <= clamp_sz(cfg_data, GSZ_W'(GRID_C_MAX));
        REG_ORDER: begin
          if (cfg_data[ORD_W-1:0] == '0) order <= ORD_W'(1);
          else if (cfg_data[ORD_W-1:0] > ORD_W'(MAX_ORDER)) order <= ORD_W'(MAX_ORDER);
          else order <= cfg_data[ORD_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // captured word
  logic signed [MU_W-1:0] mux_r, muy_r, muz_r;
  logic [FRAC_W-1:0]      frac [3];
  logic [IA_W-1:0]        ra;
  logic [IB_W-1:0]        rb;
  logic [IC_W-1:0]        rc;
  logic [RIDX_W-1:0]      rd_idx;
  logic [2*GSZ_W-1:0]     nbnc;
  logic [3*GSZ_W-1:0]     ncells;
  logic [FRAME_W-1:0]     frame_cnt;
  logic [IA_W-1:0]        ra_in;
  logic [IB_W-1:0]        rb_in;
  logic [IC_W-1:0]        rc_in;

  assign ra_in = IA_W'(mod_int(pos_a[POS_W-1:FRAC_W], na));
  assign rb_in = IB_W'(mod_int(pos_b[POS_W-1:FRAC_W], nb));
  assign rc_in = IC_W'(mod_int(pos_c[POS_W-1:FRAC_W], nc));

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mux_r   <= mu_x;
      muy_r   <= mu_y;
      muz_r   <= mu_z;
      frac[0] <= pos_a[FRAC_W-1:0];
      frac[1] <= pos_b[FRAC_W-1:0];
      frac[2] <= pos_c[FRAC_W-1:0];
      ra      <= ra_in;
      rb      <= rb_in;
      rc      <= rc_in;
      rd_idx  <= read_index;
      nbnc    <= (2*GSZ_W)'(nb) * (2*GSZ_W)'(nc);
    end
    if (cmd.rd_size) ncells <= (3*GSZ_W)'(na) * (3*GSZ_W)'(nbnc);
  end

  always_ff @(posedge clk) begin
    if (rst) frame_cnt <= '0;
    else if (cmd.frame_bump && frame_cnt != '1) frame_cnt <= frame_cnt + FRAME_W'(1);
  end

  // weight recurrence, one lane per axis
  logic [W_W-1:0]   wt   [3][MAX_ORDER];
  logic [PW-1:0]    p1   [3];
  logic [PW-1:0]    p2   [3];
  logic [DVW-1:0]   dv   [3];
  logic [ORD_W-1:0] rem  [3];
  logic [XW-1:0]    xv   [3];
  logic [XW-1:0]    qx   [3];
  logic [W_W-1:0]   here [3];
  logic [W_W-1:0]   left [3];
  logic [DVW-1:0]   dv_n [3];
  logic [ORD_W-1:0] rem_n[3];
  logic [PW:0]      tsum [3];
  logic [ORD_W-1:0] dq;
  logic [K_W-1:0]   jx, jl;

  assign dq = cmd.q - ORD_W'(1);
  assign jx = K_W'(cmd.j);
  assign jl = K_W'(cmd.j - ORD_W'(1));

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      xv[l]   = XW'(frac[l]) + (XW'(cmd.j) << FRAC_W);
      qx[l]   = (XW'(cmd.q) << FRAC_W) - xv[l];
      here[l] = (cmd.j < dq) ? wt[l][jx] : '0;
      left[l] = (cmd.j != '0) ? wt[l][jl] : '0;
      tsum[l] = (PW+1)'(p1[l]) + (PW+1)'(p2[l]) + ((PW+1)'(dq) << (FRAC_W - 1));
      {rem_n[l], dv_n[l][7:0]} = div8(rem[l], dv[l][DVW-1:DVW-8], dq);
      dv_n[l][DVW-1:8] = dv[l][DVW-9:0];
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 3; l++) begin
      if (cmd.capture) begin
        for (int k = 0; k < MAX_ORDER; k++) wt[l][k] <= (k == 0) ? ONE30 : '0;
      end else if (cmd.w_write) begin
        wt[l][jx] <= dv_n[l][W_W-1:0];
      end
      if (cmd.w_mul) begin
        p1[l] <= PW'(xv[l]) * PW'(here[l]);
        p2[l] <= PW'(qx[l]) * PW'(left[l]);
      end
      if (cmd.w_sum) begin
        dv[l]  <= DVW'(tsum[l][PW:FRAC_W]);
        rem[l] <= '0;
      end else if (cmd.w_div) begin
        dv[l]  <= dv_n[l];
        rem[l] <= rem_n[l];
      end
    end
  end

  // cell sweep counters
  logic [K_W-1:0]  ka, kb, kc;
  logic [IA_W-1:0] ia;
  logic [IB_W-1:0] ib;
  logic [IC_W-1:0] ic;
  logic [K_W-1:0]  klast;
  logic [ADDR_W-1:0] idx0;

  assign klast = K_W'(order - ORD_W'(1));
  assign idx0  = ADDR_W'((2*ADDR_W)'(ia) * (2*ADDR_W)'(nbnc)
                        + (2*ADDR_W)'(ib) * (2*ADDR_W)'(nc) + (2*ADDR_W)'(ic));

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ka <= '0;
      kb <= '0;
      kc <= '0;
      ia <= ra_in;
      ib <= rb_in;
      ic <= rc_in;
    end else if (cmd.cell_step) begin
      if (kc == klast) begin
        kc <= '0;
        ic <= rc;
        if (kb == klast) begin
          kb <= '0;
          ib <= rb;
          ka <= ka + K_W'(1);
          ia <= (ia == '0) ? IA_W'(na - GSZ_W'(1)) : ia - IA_W'(1);
        end else begin
          kb <= kb + K_W'(1);
          ib <= (ib == '0) ? IB_W'(nb - GSZ_W'(1)) : ib - IB_W'(1);
        end
      end else begin
        kc <= kc + K_W'(1);
        ic <= (ic == '0) ? IC_W'(nc - GSZ_W'(1)) : ic - IC_W'(1);
      end
    end
  end

  // cell pipeline: select, a*b weight, *c weight, dipole scale, add
  logic s1_v, s2_v, s3_v, s4_v;
  logic [ADDR_W-1:0] s1_idx, s2_idx, s3_idx, s4_idx;
  logic [W_W-1:0] s1_wa, s1_wb, s1_wc, s2_wab, s2_wc, s3_w;
  logic signed [CW-1:0] s4_cx, s4_cy, s4_cz;
  logic [2*W_W-1:0] m_ab, m_abc;
  logic signed [MU_W+W_W+1:0] m_x, m_y, m_z, w_s;

  assign m_ab  = (2*W_W)'(s1_wa) * (2*W_W)'(s1_wb) + ((2*W_W)'(1) << 29);
  assign m_abc = (2*W_W)'(s2_wab) * (2*W_W)'(s2_wc) + ((2*W_W)'(1) << 29);
  assign w_s   = signed'((MU_W+W_W+2)'(s3_w));
  assign m_x   = (MU_W+W_W+2)'(mux_r) * w_s + (MU_W+W_W+2)'(1 << 29);
  assign m_y   = (MU_W+W_W+2)'(muy_r) * w_s + (MU_W+W_W+2)'(1 << 29);
  assign m_z   = (MU_W+W_W+2)'(muz_r) * w_s + (MU_W+W_W+2)'(1 << 29);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
    end else begin
      s1_v <= cmd.cell_step;
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
    end
    s1_idx <= idx0;
    s1_wa  <= wt[0][ka];
    s1_wb  <= wt[1][kb];
    s1_wc  <= wt[2][kc];
    s2_idx <= s1_idx;
    s2_wab <= m_ab[W_W+29:30];
    s2_wc  <= s1_wc;
    s3_idx <= s2_idx;
    s3_w   <= m_abc[W_W+29:30];
    s4_idx <= s3_idx;
    s4_cx  <= m_x[CW+29:30];
    s4_cy  <= m_y[CW+29:30];
    s4_cz  <= m_z[CW+29:30];
  end

  // sum store, with one-deep forwarding for back-to-back hits on a cell
  cell_t             mem [CELLS];
  cell_t             rdata, base, upd, fwd_data;
  logic [ADDR_W-1:0] rd_addr, clr_addr, fwd_idx;
  logic              fwd_v;

  assign rd_addr = s3_v ? s3_idx : ADDR_W'(rd_idx);
  assign base    = (fwd_v && fwd_idx == s4_idx) ? fwd_data : rdata;
  assign upd     = sat_add(base, s4_cx, s4_cy, s4_cz);

  always_ff @(posedge clk) begin
    if (cmd.clear) mem[clr_addr] <= '0;
    else if (s4_v) mem[s4_idx] <= upd;
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      fwd_v    <= 1'b0;
    end else begin
      if (cmd.clear) clr_addr <= clr_addr + ADDR_W'(1);
      fwd_v <= s4_v;
    end
    fwd_idx  <= s4_idx;
    fwd_data <= upd;
  end

  // result register
  logic in_range;
  assign in_range = (3*GSZ_W)'(rd_idx) < ncells;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.out_load) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
    if (cmd.out_load) begin
      sum_x  <= in_range ? rdata.x : '0;
      sum_y  <= in_range ? rdata.y : '0;
      sum_z  <= in_range ? rdata.z : '0;
      frames <= frame_cnt;
    end
  end

  assign status.order      = order;
  assign status.cell_last  = (ka == klast) && (kb == klast) && (kc == klast);
  assign status.pipe_busy  = s1_v | s2_v | s3_v | s4_v;
  assign status.clear_last = (clr_addr == '1);
  assign status.out_free   = !out_valid || !out_stall;

endmodule

FILE: test/tb.sv
// Testbench for the B-spline dipole grid spreader: random and directed words, scoreboard check.
`timescale 1ns / 1ps

module tb;
  import bsds_pkg::*;

  // ---- clock and reset ----
  logic clk = 1'b0;
  logic rst = 1'b1;

  initial begin
    forever #10 clk = ~clk;
  end

  // ---- block ports ----
  logic                     cfg_we = 1'b0;
  logic [CFG_IW-1:0]        cfg_index = '0;
  logic [CFG_DW-1:0]        cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [1:0]               func = FUNC_FRAME;
  logic signed [MU_W-1:0]   mu_x = '0, mu_y = '0, mu_z = '0;
  logic [POS_W-1:0]         pos_a = '0, pos_b = '0, pos_c = '0;
  logic [RIDX_W-1:0]        read_index = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [SUM_W-1:0]  sum_x, sum_y, sum_z;
  logic [FRAME_W-1:0]       frames;

  // function code with no meaning: the block ignores it
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  bspline_dipole_grid_spreader_core i_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .mu_x(mu_x), .mu_y(mu_y), .mu_z(mu_z),
    .pos_a(pos_a), .pos_b(pos_b), .pos_c(pos_c), .read_index(read_index),
    .out_valid(out_valid), .out_stall(out_stall),
    .sum_x(sum_x), .sum_y(sum_y), .sum_z(sum_z), .frames(frames)
  );

  // ---- word types ----
  typedef struct packed {
    logic [1:0]             fn;
    logic signed [MU_W-1:0] mx, my, mz;
    logic [POS_W-1:0]       pa, pb, pc;
    logic [RIDX_W-1:0]      ridx;
  } spread_word_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sx, sy, sz;
    logic [FRAME_W-1:0]      fr;
  } cell_read_t;

  // ---- predictor state (own copy of the grid) ----
  longint         grid_x [CELLS];
  longint         grid_y [CELLS];
  longint         grid_z [CELLS];
  longint unsigned frame_cnt;
  int             na_reg = 32, nb_reg = 32, nc_reg = 32, ord_reg = 4;

  spread_word_t   pending_words[$];
  cell_read_t     expected_reads[$];

  int  errors = 0;
  int  n_reads = 0, n_spreads = 0;
  longint cycles = 0;
  bit  hold_req = 1'b0;   // long receiver hold-off request
  bit  quiet = 1'b0;      // no idling at all
  bit  in_taken = 1'b0;   // word taken at the last rising edge

  function automatic int eff(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // spline weights in Q1.30 for fraction f (Q0.16)
  function automatic void spline_weights(longint unsigned f, int p,
                                         output longint unsigned w [MAX_ORDER]);
    longint unsigned d, x, qx, here, left, num;
    for (int j = 0; j < MAX_ORDER; j++) w[j] = 0;
    w[0] = 64'd1 << 30;
    for (int q = 2; q <= p; q++) begin
      d = longint'(q - 1) << 16;
      for (int j = q - 1; j >= 0; j--) begin
        x = f + (longint'(j) << 16);
        qx = (longint'(q) << 16) - x;
        here = (j < q - 1) ? w[j] : 0;
        left = (j > 0) ? w[j-1] : 0;
        num = x * here + qx * left;
        w[j] = (num + (d >> 1)) / d;
      end
    end
  endfunction

  function automatic longint weigh(longint mu, longint unsigned w);
    longint prod;
    prod = mu * longint'(w) + (64'sd1 <<< 29);
    return prod >>> 30;
  endfunction

  function automatic longint sat48(longint v);
    if (v > (64'sd1 <<< 47) - 1) return (64'sd1 <<< 47) - 1;
    if (v < -(64'sd1 <<< 47)) return -(64'sd1 <<< 47);
    return v;
  endfunction

  // work one word through the grid model, queue the read result if any
  task automatic predict_word(spread_word_t wd);
    int na, nb, nc, p, ra, rb, rc, ia, ib, ic, idx;
    longint unsigned wa [MAX_ORDER], wb [MAX_ORDER], wc [MAX_ORDER];
    longint unsigned wab, w;
    cell_read_t r;
    na = eff(na_reg, GRID_A_MAX); nb = eff(nb_reg, GRID_B_MAX);
    nc = eff(nc_reg, GRID_C_MAX); p = eff(ord_reg, MAX_ORDER);
    case (wd.fn)
      FUNC_SPREAD: begin
        n_spreads++;
        ra = int'(wd.pa >> FRAC_W) % na; rb = int'(wd.pb >> FRAC_W) % nb;
        rc = int'(wd.pc >> FRAC_W) % nc;
        spline_weights(64'(wd.pa[FRAC_W-1:0]), p, wa);
        spline_weights(64'(wd.pb[FRAC_W-1:0]), p, wb);
        spline_weights(64'(wd.pc[FRAC_W-1:0]), p, wc);
        for (int ka = 0; ka < p; ka++) begin
          ia = (ra + na - (ka % na)) % na;
          for (int kb = 0; kb < p; kb++) begin
            ib = (rb + nb - (kb % nb)) % nb;
            wab = (wa[ka] * wb[kb] + (64'd1 << 29)) >> 30;
            for (int kc = 0; kc < p; kc++) begin
              ic = (rc + nc - (kc % nc)) % nc;
              w = (wab * wc[kc] + (64'd1 << 29)) >> 30;
              idx = ia * nb * nc + ib * nc + ic;
              if (idx < CELLS) begin
                grid_x[idx] = sat48(grid_x[idx] + weigh(longint'(wd.mx), w));
                grid_y[idx] = sat48(grid_y[idx] + weigh(longint'(wd.my), w));
                grid_z[idx] = sat48(grid_z[idx] + weigh(longint'(wd.mz), w));
              end
            end
          end
        end
      end
      FUNC_FRAME: if (frame_cnt != 64'hFFFF_FFFF) frame_cnt++;
      FUNC_READ: begin
        idx = int'(wd.ridx);
        r = '0;
        if (idx < na * nb * nc) begin
          r.sx = SUM_W'(grid_x[idx]); r.sy = SUM_W'(grid_y[idx]);
          r.sz = SUM_W'(grid_z[idx]);
        end
        r.fr = frame_cnt[31:0];
        expected_reads.push_back(r);
      end
      default: ;
    endcase
  endtask

  // ---- driver: offers queued words, idles about a third of the time ----
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      // previous word (if any) taken at the last rising edge
      if (pending_words.size() > 0 && (quiet || $urandom_range(99) >= 34)) begin
        func <= pending_words[0].fn;
        mu_x <= pending_words[0].mx; mu_y <= pending_words[0].my;
        mu_z <= pending_words[0].mz;
        pos_a <= pending_words[0].pa; pos_b <= pending_words[0].pb;
        pos_c <= pending_words[0].pc;
        read_index <= pending_words[0].ridx;
        pending_words.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // predict on acceptance
  always @(posedge clk) begin
    in_taken <= !rst && in_valid && !in_stall;
    if (!rst && in_valid && !in_stall)
      predict_word('{func, mu_x, mu_y, mu_z, pos_a, pos_b, pos_c, read_index});
  end

  // ---- receiver stall, with a long hold-off counted here ----
  int hold_left = 0;
  always @(negedge clk) begin
    if (hold_req && hold_left == 0) hold_left = 3000;
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      if (hold_left == 0) hold_req = 1'b0;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 34);
    end
  end

  // ---- monitor ----
  always @(posedge clk) begin
    cycles++;
    if (!rst && out_valid && !out_stall) begin
      n_reads++;
      if (expected_reads.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected read word: %h %h %h %h",
                                   sum_x, sum_y, sum_z, frames);
      end else begin
        cell_read_t e;
        e = expected_reads.pop_front();
        if (e.sx !== sum_x || e.sy !== sum_y || e.sz !== sum_z || e.fr !== frames) begin
          errors++;
          if (errors <= 10)
            $display("read mismatch: exp %h %h %h %h got %h %h %h %h",
                     e.sx, e.sy, e.sz, e.fr, sum_x, sum_y, sum_z, frames);
        end
      end
    end
    if (cycles > 64'd3_000_000) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---- stimulus helpers ----
  function automatic spread_word_t spread_of(int mx, int my, int mz, int pa, int pb, int pc);
    spread_word_t w;
    w = '0;
    w.fn = FUNC_SPREAD; w.mx = MU_W'(mx); w.my = MU_W'(my); w.mz = MU_W'(mz);
    w.pa = POS_W'(pa); w.pb = POS_W'(pb); w.pc = POS_W'(pc);
    w.ridx = RIDX_W'($urandom);
    return w;
  endfunction

  function automatic spread_word_t read_of(int idx);
    spread_word_t w;
    w = '0;
    w.fn = FUNC_READ; w.ridx = RIDX_W'(idx);
    w.mx = MU_W'($urandom); w.my = MU_W'($urandom); w.mz = MU_W'($urandom);
    w.pa = POS_W'($urandom); w.pb = POS_W'($urandom); w.pc = POS_W'($urandom);
    return w;
  endfunction

  function automatic spread_word_t frame_of();
    spread_word_t w;
    w = read_of(0);
    w.fn = FUNC_FRAME;
    return w;
  endfunction

  function automatic int rand_pos();
    // mostly in the used range, sometimes anywhere (wraps)
    return ($urandom_range(3) == 0) ? $urandom_range(2097151)
                                    : $urandom_range(32'h10_0000);
  endfunction

  function automatic int rand_mu();
    case ($urandom_range(5))
      0: return -8388608;
      1: return 8388607;
      default: return $signed($urandom_range(16777215) - 8388608);
    endcase
  endfunction

  task automatic wait_drained();
    while (pending_words.size() > 0 || in_valid || expected_reads.size() > 0)
      @(posedge clk);
    // spreads give no result: allow the longest spread to finish
    repeat (400) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IW-1:0] idx, int val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= CFG_DW'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_NA:    na_reg = val & 63;
      REG_NB:    nb_reg = val & 63;
      REG_NC:    nc_reg = val & 63;
      REG_ORDER: ord_reg = val & 7;
      default: ;
    endcase
  endtask

  // random phase: a mix of spreads, frame words, ignored words and reads of random cells
  task automatic random_phase(int count);
    int pa, pb, pc, nbc;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          pa = rand_pos(); pb = rand_pos(); pc = rand_pos();
          pending_words.push_back(spread_of(rand_mu(), rand_mu(), rand_mu(), pa, pb, pc));
        end
        4: pending_words.push_back(frame_of());
        5: begin
          spread_word_t w;
          w = frame_of(); w.fn = FUNC_UNUSED;   // ignored by the block
          pending_words.push_back(w);
        end
        6: pending_words.push_back(read_of($urandom_range(32767)));
        default: begin
          nbc = eff(nb_reg, 32) * eff(nc_reg, 32);
          pending_words.push_back(read_of($urandom_range(eff(na_reg, 32) * nbc - 1)));
        end
      endcase
    end
  endtask

  initial begin
    for (int i = 0; i < CELLS; i++) begin
      grid_x[i] = 0; grid_y[i] = 0; grid_z[i] = 0;
    end
    frame_cnt = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, every function, wrapping
    pending_words.push_back(read_of(0));
    pending_words.push_back(spread_of(8388607, -8388608, 1, 0, 0, 0));
    pending_words.push_back(spread_of(-8388608, 8388607, -1, 2097151, 2097151, 2097151));
    pending_words.push_back(spread_of(65536, 0, -65536, 32'h8000, 32'h1_8000, 32'h1F_FFFF));
    pending_words.push_back(frame_of());
    pending_words.push_back(read_of(0));
    pending_words.push_back(read_of(32767));
    pending_words.push_back(read_of(31 * 1024 + 31 * 32 + 31));
    begin
      spread_word_t w;
      w = frame_of(); w.fn = FUNC_UNUSED;
      pending_words.push_back(w);
    end
    wait_drained();

    // order 1: pile maxima into one cell, then read it (far below saturation)
    write_reg(REG_ORDER, 1);
    for (int i = 0; i < 12; i++)
      pending_words.push_back(spread_of(8388607, -8388608, 8388607, 5 << 16, 0, 0));
    pending_words.push_back(read_of(5 * 1024));
    wait_drained();

    // several settings, extremes among them (0 and out of range clamp)
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin write_reg(REG_NA, 1); write_reg(REG_NB, 1); write_reg(REG_NC, 1);
                 write_reg(REG_ORDER, 6); end
        1: begin write_reg(REG_NA, 0); write_reg(REG_NB, 63); write_reg(REG_NC, 7);
                 write_reg(REG_ORDER, 0); end
        2: begin write_reg(REG_NA, 4); write_reg(REG_NB, 5); write_reg(REG_NC, 3);
                 write_reg(REG_ORDER, 7); end
        3: begin write_reg(REG_NA, 32); write_reg(REG_NB, 32); write_reg(REG_NC, 32);
                 write_reg(REG_ORDER, 2); end
        default: begin
          write_reg(REG_NA, $urandom_range(1, 32)); write_reg(REG_NB, $urandom_range(1, 32));
          write_reg(REG_NC, $urandom_range(1, 32)); write_reg(REG_ORDER, $urandom_range(1, 6));
        end
      endcase
      if (ph == 4) quiet = 1'b1;        // a stretch with no idling
      if (ph == 5) begin quiet = 1'b0; hold_req = 1'b1; end
      random_phase(175);
      wait_drained();
    end
    repeat (50) @(posedge clk);

    $display("covered %0d spread words and %0d cell reads over 10 grid settings",
             n_spreads, n_reads);
    if (errors == 0 && expected_reads.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
